// ===== design/rrs_pkg.sv =====
// Shared types, sizes and codes for the rectangle region store.
// Used by rrs_front, rrs_queue, rrs_back and rectangle_region_store.
`default_nettype none
package rrs_pkg;
   localparam int CAPACITY         = 16;
   localparam int SCRATCH_CAPACITY = 8;
   localparam int COORD_BITS       = 16;

   localparam int RIDX_W = $clog2(CAPACITY);
   localparam int RCNT_W = $clog2(CAPACITY + 1);
   localparam int PIDX_W = $clog2(SCRATCH_CAPACITY);
   localparam int PCNT_W = $clog2(SCRATCH_CAPACITY + 1);
   localparam int CNT_W  = (RCNT_W > PCNT_W) ? RCNT_W : PCNT_W;

   localparam int ACT_W  = 4;
   localparam int IDX_W  = 4;
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [ACT_W-1:0] ACT_CLEAR  = 4'd0;
   localparam logic [ACT_W-1:0] ACT_ADD    = 4'd1;
   localparam logic [ACT_W-1:0] ACT_SUB    = 4'd2;
   localparam logic [ACT_W-1:0] ACT_CLIP   = 4'd3;
   localparam logic [ACT_W-1:0] ACT_HIT    = 4'd4;
   localparam logic [ACT_W-1:0] ACT_OVL    = 4'd5;
   localparam logic [ACT_W-1:0] ACT_BOUNDS = 4'd6;
   localparam logic [ACT_W-1:0] ACT_OFFSET = 4'd7;
   localparam logic [ACT_W-1:0] ACT_READ   = 4'd8;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type l;
      coord_type t;
      coord_type r;
      coord_type b;
   } box_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CLEAR,
      OP_ADD,
      OP_SUB,
      OP_CLIP,
      OP_HIT,
      OP_OVL,
      OP_BOUNDS,
      OP_OFFSET,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type             op;
      box_type            a;
      logic [IDX_W-1:0]   idx;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK,
      ST_SHIFT,
      ST_SUB_WALK,
      ST_SUB_APP,
      ST_ADD_CHK,
      ST_ADD_INIT,
      ST_ADD_NEXT,
      ST_ADD_APP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [RCNT_W-1:0]  count;
      logic               err;
      logic               ans;
      box_type            o;
   } rsp_type;
endpackage
`default_nettype wire

// ===== design/rrs_front.sv =====
// Command front end: takes request words and decodes the action code.
// Depends on rrs_pkg; feeds rrs_queue.
`default_nettype none
module rrs_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [rrs_pkg::ACT_W-1:0]   req_action,
   input  wire rrs_pkg::coord_type          req_rect_left,
   input  wire rrs_pkg::coord_type          req_rect_top,
   input  wire rrs_pkg::coord_type          req_rect_right,
   input  wire rrs_pkg::coord_type          req_rect_bottom,
   input  wire logic [rrs_pkg::IDX_W-1:0]   req_entry_index,
   input  wire logic                        q_full,
   output logic                             push,
   output rrs_pkg::cmd_type                 cmd
);
   logic             vld_ff, vld_in;
   rrs_pkg::cmd_type cmd_ff, cmd_in;
   rrs_pkg::op_type  op_dec;
   logic             accept;

   always_comb begin
      unique case (req_action)
         rrs_pkg::ACT_CLEAR:  op_dec = rrs_pkg::OP_CLEAR;
         rrs_pkg::ACT_ADD:    op_dec = rrs_pkg::OP_ADD;
         rrs_pkg::ACT_SUB:    op_dec = rrs_pkg::OP_SUB;
         rrs_pkg::ACT_CLIP:   op_dec = rrs_pkg::OP_CLIP;
         rrs_pkg::ACT_HIT:    op_dec = rrs_pkg::OP_HIT;
         rrs_pkg::ACT_OVL:    op_dec = rrs_pkg::OP_OVL;
         rrs_pkg::ACT_BOUNDS: op_dec = rrs_pkg::OP_BOUNDS;
         rrs_pkg::ACT_OFFSET: op_dec = rrs_pkg::OP_OFFSET;
         rrs_pkg::ACT_READ:   op_dec = rrs_pkg::OP_READ;
         default:             op_dec = rrs_pkg::OP_NOP;
      endcase
   end

   assign busy   = vld_ff && q_full;
   assign accept = start && !busy;
   assign push   = vld_ff && !q_full;
   assign cmd    = cmd_ff;

   always_comb begin
      vld_in = accept || (vld_ff && q_full);
      cmd_in = cmd_ff;
      if (accept) begin
         cmd_in.op  = op_dec;
         cmd_in.a   = '{l: req_rect_left, t: req_rect_top,
                        r: req_rect_right, b: req_rect_bottom};
         cmd_in.idx = req_entry_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      cmd_ff <= cmd_in;
   end
endmodule
`default_nettype wire

// ===== design/rrs_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on rrs_pkg.
`default_nettype none
module rrs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rrs_pkg::cmd_type  wr_cmd,
   output logic                   full,
   output logic                   not_empty,
   input  wire logic              pop,
   output rrs_pkg::cmd_type       rd_cmd
);
   rrs_pkg::cmd_type              slot_ff [rrs_pkg::QDEPTH];
   logic [rrs_pkg::QPTR_W-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [rrs_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;

   assign full      = (cnt_ff == rrs_pkg::QCNT_W'(rrs_pkg::QDEPTH));
   assign not_empty = (cnt_ff != '0);
   assign rd_cmd    = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = (wp_ff == rrs_pkg::QPTR_W'(rrs_pkg::QDEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == rrs_pkg::QPTR_W'(rrs_pkg::QDEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= wr_cmd;
      end
   end
endmodule
`default_nettype wire

// ===== design/rrs_back.sv =====
// Execution engine: rectangle list, scratch piece list and the walk sequencer.
// Depends on rrs_pkg; takes commands from rrs_queue.
`default_nettype none
module rrs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire rrs_pkg::cmd_type  cmd,
   output logic                   cmd_pop,
   output rrs_pkg::rsp_type       rsp
);
   localparam int CNT_W = rrs_pkg::CNT_W;

   function automatic logic box_empty(rrs_pkg::box_type x);
      return (x.r <= x.l) || (x.b <= x.t);
   endfunction

   function automatic logic box_touch(rrs_pkg::box_type x, rrs_pkg::box_type y);
      return (x.r > y.l) && (x.b > y.t) && (x.l < y.r) && (x.t < y.b);
   endfunction

   rrs_pkg::box_type rect_mem  [rrs_pkg::CAPACITY];
   rrs_pkg::box_type piece_mem [rrs_pkg::SCRATCH_CAPACITY];

   rrs_pkg::state_type          state_ff, state_in, ret_ff, ret_in;
   logic [rrs_pkg::RCNT_W-1:0]  rcnt_ff, rcnt_in;
   logic [rrs_pkg::PCNT_W-1:0]  pcnt_ff, pcnt_in;
   logic                        err_ff, err_in;
   rrs_pkg::cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]            i_ff, i_in, j_ff, j_in, k_ff, k_in, lim_ff, lim_in;
   logic                        tgt_ff, tgt_in;
   rrs_pkg::box_type            s_ff, s_in, e_ff, e_in, in_ff, in_in, o_ff, o_in;
   logic [1:0]                  pc_ff, pc_in;
   logic                        ans_ff, ans_in;

   logic [CNT_W-1:0]            li, l_cnt, l_cap;
   logic [rrs_pkg::RIDX_W-1:0]  rect_ra, rect_wa;
   logic [rrs_pkg::PIDX_W-1:0]  piece_wa;
   rrs_pkg::box_type            rect_rd, piece_rd, l_rd, rect_wd, piece_wd;
   logic                        rect_we, piece_we;
   rrs_pkg::box_type            clip_box, off_box, isect, piece_box, bnd_box;
   logic                        a_empty, walk_end, clip_gone, sub_end, shift_end;
   logic                        ovl_hit, add_out, next_end, app_end, app_full;
   logic                        pc_cond, pc_full, s_empty;

   assign li      = (state_ff == rrs_pkg::ST_SHIFT) ? j_ff + 1'b1 : i_ff;
   assign l_cnt   = tgt_ff ? CNT_W'(pcnt_ff) : CNT_W'(rcnt_ff);
   assign l_cap   = tgt_ff ? CNT_W'(rrs_pkg::SCRATCH_CAPACITY) : CNT_W'(rrs_pkg::CAPACITY);

   always_comb begin
      unique case (state_ff)
         rrs_pkg::ST_DISPATCH: rect_ra = rrs_pkg::RIDX_W'(cmd_ff.idx);
         rrs_pkg::ST_ADD_NEXT: rect_ra = k_ff[rrs_pkg::RIDX_W-1:0];
         default:              rect_ra = li[rrs_pkg::RIDX_W-1:0];
      endcase
   end

   assign rect_rd  = rect_mem[rect_ra];
   assign piece_rd = piece_mem[li[rrs_pkg::PIDX_W-1:0]];
   assign l_rd     = tgt_ff ? piece_rd : rect_rd;

   always_comb begin
      clip_box.l = (rect_rd.l < cmd_ff.a.l) ? cmd_ff.a.l : rect_rd.l;
      clip_box.t = (rect_rd.t < cmd_ff.a.t) ? cmd_ff.a.t : rect_rd.t;
      clip_box.r = (rect_rd.r > cmd_ff.a.r) ? cmd_ff.a.r : rect_rd.r;
      clip_box.b = (rect_rd.b > cmd_ff.a.b) ? cmd_ff.a.b : rect_rd.b;
      off_box.l  = rect_rd.l + cmd_ff.a.l;
      off_box.r  = rect_rd.r + cmd_ff.a.l;
      off_box.t  = rect_rd.t + cmd_ff.a.t;
      off_box.b  = rect_rd.b + cmd_ff.a.t;
      bnd_box.l  = (rect_rd.l < o_ff.l) ? rect_rd.l : o_ff.l;
      bnd_box.t  = (rect_rd.t < o_ff.t) ? rect_rd.t : o_ff.t;
      bnd_box.r  = (rect_rd.r > o_ff.r) ? rect_rd.r : o_ff.r;
      bnd_box.b  = (rect_rd.b > o_ff.b) ? rect_rd.b : o_ff.b;
      isect.l    = (l_rd.l > s_ff.l) ? l_rd.l : s_ff.l;
      isect.t    = (l_rd.t > s_ff.t) ? l_rd.t : s_ff.t;
      isect.r    = (l_rd.r < s_ff.r) ? l_rd.r : s_ff.r;
      isect.b    = (l_rd.b < s_ff.b) ? l_rd.b : s_ff.b;
      unique case (pc_ff)
         2'd0: begin
            pc_cond   = (in_ff.b != e_ff.b);
            piece_box = '{l: e_ff.l, t: in_ff.b, r: e_ff.r, b: e_ff.b};
         end
         2'd1: begin
            pc_cond   = (in_ff.t != e_ff.t);
            piece_box = '{l: e_ff.l, t: e_ff.t, r: e_ff.r, b: in_ff.t};
         end
         2'd2: begin
            pc_cond   = (in_ff.r != e_ff.r);
            piece_box = '{l: in_ff.r, t: in_ff.t, r: e_ff.r, b: in_ff.b};
         end
         default: begin
            pc_cond   = (in_ff.l != e_ff.l);
            piece_box = '{l: e_ff.l, t: in_ff.t, r: in_ff.l, b: in_ff.b};
         end
      endcase
   end

   assign a_empty   = box_empty(cmd_ff.a);
   assign walk_end  = (i_ff >= CNT_W'(rcnt_ff));
   assign clip_gone = box_empty(clip_box);
   assign sub_end   = (i_ff >= lim_ff);
   assign shift_end = (j_ff >= l_cnt);
   assign ovl_hit   = box_touch(l_rd, s_ff);
   assign add_out   = (rect_rd.l < cmd_ff.a.l) || (rect_rd.r > cmd_ff.a.r) ||
                      (rect_rd.t < cmd_ff.a.t) || (rect_rd.b > cmd_ff.a.b);
   assign next_end  = (k_ff >= CNT_W'(rcnt_ff));
   assign app_end   = (i_ff >= CNT_W'(pcnt_ff));
   assign app_full  = (rcnt_ff >= rrs_pkg::RCNT_W'(rrs_pkg::CAPACITY));
   assign pc_full   = (l_cnt >= l_cap);
   assign s_empty   = box_empty(rect_rd);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrs_pkg::ST_IDLE: begin
            if (cmd_valid) state_in = rrs_pkg::ST_DISPATCH;
         end
         rrs_pkg::ST_DISPATCH: begin
            unique case (cmd_ff.op)
               rrs_pkg::OP_ADD:
                  state_in = (a_empty || err_ff) ? rrs_pkg::ST_RESP : rrs_pkg::ST_ADD_CHK;
               rrs_pkg::OP_SUB:
                  state_in = a_empty ? rrs_pkg::ST_RESP : rrs_pkg::ST_SUB_WALK;
               rrs_pkg::OP_OVL:
                  state_in = a_empty ? rrs_pkg::ST_RESP : rrs_pkg::ST_WALK;
               rrs_pkg::OP_CLIP, rrs_pkg::OP_HIT, rrs_pkg::OP_BOUNDS, rrs_pkg::OP_OFFSET:
                  state_in = rrs_pkg::ST_WALK;
               default:
                  state_in = rrs_pkg::ST_RESP;
            endcase
         end
         rrs_pkg::ST_WALK: begin
            if (walk_end) state_in = rrs_pkg::ST_RESP;
            else if (cmd_ff.op == rrs_pkg::OP_CLIP && clip_gone) state_in = rrs_pkg::ST_SHIFT;
         end
         rrs_pkg::ST_SHIFT: begin
            if (shift_end) state_in = ret_ff;
         end
         rrs_pkg::ST_SUB_WALK: begin
            if (sub_end) state_in = tgt_ff ? rrs_pkg::ST_ADD_NEXT : rrs_pkg::ST_RESP;
            else if (ovl_hit) state_in = rrs_pkg::ST_SHIFT;
         end
         rrs_pkg::ST_SUB_APP: begin
            if (pc_cond && pc_full) state_in = rrs_pkg::ST_RESP;
            else if (&pc_ff) state_in = rrs_pkg::ST_SUB_WALK;
         end
         rrs_pkg::ST_ADD_CHK: begin
            if (walk_end) state_in = rrs_pkg::ST_RESP;
            else if (add_out) state_in = rrs_pkg::ST_ADD_INIT;
         end
         rrs_pkg::ST_ADD_INIT: state_in = rrs_pkg::ST_ADD_NEXT;
         rrs_pkg::ST_ADD_NEXT: begin
            if (next_end) state_in = rrs_pkg::ST_ADD_APP;
            else if (!s_empty) state_in = rrs_pkg::ST_SUB_WALK;
         end
         rrs_pkg::ST_ADD_APP: begin
            if (app_end || app_full) state_in = rrs_pkg::ST_RESP;
         end
         rrs_pkg::ST_RESP: state_in = rrs_pkg::ST_IDLE;
         default: state_in = rrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ret_in   = ret_ff;
      rcnt_in  = rcnt_ff;
      pcnt_in  = pcnt_ff;
      err_in   = err_ff;
      cmd_in   = cmd_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      lim_in   = lim_ff;
      tgt_in   = tgt_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      in_in    = in_ff;
      o_in     = o_ff;
      pc_in    = pc_ff;
      ans_in   = ans_ff;
      cmd_pop  = 1'b0;
      rect_we  = 1'b0;
      rect_wa  = li[rrs_pkg::RIDX_W-1:0];
      rect_wd  = rect_rd;
      piece_we = 1'b0;
      piece_wa = li[rrs_pkg::PIDX_W-1:0];
      piece_wd = piece_rd;
      rsp      = '{valid: 1'b0, count: rcnt_ff, err: err_ff, ans: ans_ff, o: o_ff};
      unique case (state_ff)
         rrs_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               ans_in  = 1'b0;
               o_in    = '0;
               tgt_in  = 1'b0;
               i_in    = '0;
            end
         end
         rrs_pkg::ST_DISPATCH: begin
            unique case (cmd_ff.op)
               rrs_pkg::OP_CLEAR: begin
                  rcnt_in = '0;
                  err_in  = 1'b0;
               end
               rrs_pkg::OP_SUB: begin
                  s_in   = cmd_ff.a;
                  lim_in = CNT_W'(rcnt_ff);
               end
               rrs_pkg::OP_READ: begin
                  if (rrs_pkg::RCNT_W'(cmd_ff.idx) < rcnt_ff) begin
                     ans_in = 1'b1;
                     o_in   = rect_rd;
                  end
               end
               default: begin
               end
            endcase
         end
         rrs_pkg::ST_WALK: begin
            if (!walk_end) begin
               unique case (cmd_ff.op)
                  rrs_pkg::OP_CLIP: begin
                     if (clip_gone) begin
                        rcnt_in = rcnt_ff - 1'b1;
                        j_in    = i_ff;
                        ret_in  = rrs_pkg::ST_WALK;
                     end else begin
                        rect_we = 1'b1;
                        rect_wd = clip_box;
                        i_in    = i_ff + 1'b1;
                     end
                  end
                  rrs_pkg::OP_HIT: begin
                     if (cmd_ff.a.l >= rect_rd.l && cmd_ff.a.l < rect_rd.r &&
                         cmd_ff.a.t >= rect_rd.t && cmd_ff.a.t < rect_rd.b) ans_in = 1'b1;
                     i_in = i_ff + 1'b1;
                  end
                  rrs_pkg::OP_OVL: begin
                     if (!s_empty && box_touch(rect_rd, cmd_ff.a)) ans_in = 1'b1;
                     i_in = i_ff + 1'b1;
                  end
                  rrs_pkg::OP_BOUNDS: begin
                     o_in = (i_ff == '0) ? rect_rd : bnd_box;
                     i_in = i_ff + 1'b1;
                  end
                  rrs_pkg::OP_OFFSET: begin
                     rect_we = 1'b1;
                     rect_wd = off_box;
                     i_in    = i_ff + 1'b1;
                  end
                  default: i_in = i_ff + 1'b1;
               endcase
            end
         end
         rrs_pkg::ST_SHIFT: begin
            if (!shift_end) begin
               if (tgt_ff) begin
                  piece_we = 1'b1;
                  piece_wa = j_ff[rrs_pkg::PIDX_W-1:0];
                  piece_wd = piece_rd;
               end else begin
                  rect_we = 1'b1;
                  rect_wa = j_ff[rrs_pkg::RIDX_W-1:0];
                  rect_wd = rect_rd;
               end
               j_in = j_ff + 1'b1;
            end
         end
         rrs_pkg::ST_SUB_WALK: begin
            if (sub_end) begin
               k_in = k_ff + 1'b1;
            end else if (ovl_hit) begin
               e_in   = l_rd;
               in_in  = isect;
               j_in   = i_ff;
               pc_in  = '0;
               ret_in = rrs_pkg::ST_SUB_APP;
               if (tgt_ff) pcnt_in = pcnt_ff - 1'b1;
               else rcnt_in = rcnt_ff - 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         rrs_pkg::ST_SUB_APP: begin
            if (pc_cond && pc_full) begin
               rcnt_in = '0;
               err_in  = 1'b1;
               if (tgt_ff) pcnt_in = '0;
            end else begin
               if (pc_cond) begin
                  if (tgt_ff) begin
                     piece_we = 1'b1;
                     piece_wa = pcnt_ff[rrs_pkg::PIDX_W-1:0];
                     piece_wd = piece_box;
                     pcnt_in  = pcnt_ff + 1'b1;
                  end else begin
                     rect_we = 1'b1;
                     rect_wa = rcnt_ff[rrs_pkg::RIDX_W-1:0];
                     rect_wd = piece_box;
                     rcnt_in = rcnt_ff + 1'b1;
                  end
               end
               pc_in = pc_ff + 1'b1;
               if (&pc_ff) lim_in = lim_ff - 1'b1;
            end
         end
         rrs_pkg::ST_ADD_CHK: begin
            if (walk_end) begin
               rect_we = 1'b1;
               rect_wa = '0;
               rect_wd = cmd_ff.a;
               rcnt_in = rrs_pkg::RCNT_W'(1);
            end else if (!add_out) begin
               i_in = i_ff + 1'b1;
            end
         end
         rrs_pkg::ST_ADD_INIT: begin
            piece_we = 1'b1;
            piece_wa = '0;
            piece_wd = cmd_ff.a;
            pcnt_in  = rrs_pkg::PCNT_W'(1);
            k_in     = '0;
            tgt_in   = 1'b1;
         end
         rrs_pkg::ST_ADD_NEXT: begin
            i_in = '0;
            if (!next_end) begin
               if (s_empty) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  s_in   = rect_rd;
                  lim_in = CNT_W'(pcnt_ff);
               end
            end
         end
         rrs_pkg::ST_ADD_APP: begin
            if (!app_end) begin
               if (app_full) begin
                  rcnt_in = '0;
                  err_in  = 1'b1;
               end else begin
                  rect_we = 1'b1;
                  rect_wa = rcnt_ff[rrs_pkg::RIDX_W-1:0];
                  rect_wd = piece_rd;
                  rcnt_in = rcnt_ff + 1'b1;
                  i_in    = i_ff + 1'b1;
               end
            end
         end
         rrs_pkg::ST_RESP: rsp.valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrs_pkg::ST_IDLE;
         rcnt_ff  <= '0;
         pcnt_ff  <= '0;
         err_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rcnt_ff  <= rcnt_in;
         pcnt_ff  <= pcnt_in;
         err_ff   <= err_in;
      end
      ret_ff <= ret_in;
      cmd_ff <= cmd_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      lim_ff <= lim_in;
      tgt_ff <= tgt_in;
      s_ff   <= s_in;
      e_ff   <= e_in;
      in_ff  <= in_in;
      o_ff   <= o_in;
      pc_ff  <= pc_in;
      ans_ff <= ans_in;
      if (rect_we) rect_mem[rect_wa] <= rect_wd;
      if (piece_we) piece_mem[piece_wa] <= piece_wd;
   end

   a_rcnt_max: assert property (@(posedge clock) disable iff (reset)
      rcnt_ff <= rrs_pkg::RCNT_W'(rrs_pkg::CAPACITY))
      else $error("region count above capacity");

   a_pcnt_max: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= rrs_pkg::PCNT_W'(rrs_pkg::SCRATCH_CAPACITY))
      else $error("piece count above scratch capacity");

   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |=> !rsp.valid && state_ff == rrs_pkg::ST_IDLE)
      else $error("response strobe longer than one cycle");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrs_pkg::ST_DISPATCH && cmd_ff.op == rrs_pkg::OP_CLEAR)
      |=> (rcnt_ff == '0 && !err_ff && state_ff == rrs_pkg::ST_RESP))
      else $error("clear did not empty the region");
endmodule
`default_nettype wire

// ===== design/rectangle_region_store.sv =====
// Top level of the rectangle region store: front end, command queue, engine.
// Depends on rrs_pkg, rrs_front, rrs_queue and rrs_back.
//
// Usage:
//   A request word is taken at a rising edge where start is high and busy is
//   low. Its action selects clear, add, subtract, clip, point hit, overlap,
//   bounds, offset or read entry on the stored list of up to CAPACITY
//   rectangles. Every request gives exactly one response, shown for one cycle
//   with rsp_valid high, in request order.
//   Subtract and add walk the list one entry per cycle while no entry is
//   removed; each removed entry is closed up by shifting the entries behind
//   it, then its four pieces are checked and appended as needed, and add
//   also runs over the scratch list once per non-empty stored rectangle.
//   The engine has a single-entry read port and a shift sequencer.
//   Up to three requests are held ahead of the engine (front register plus
//   two queue slots); busy rises only when all are taken.
//   Reset empties the region, clears the error flag and the queue.
//   Responses cannot be stalled: the receiver must take each strobe.
`default_nettype none
module rectangle_region_store (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [rrs_pkg::ACT_W-1:0]    req_action,
   input  wire rrs_pkg::coord_type           req_rect_left,
   input  wire rrs_pkg::coord_type           req_rect_top,
   input  wire rrs_pkg::coord_type           req_rect_right,
   input  wire rrs_pkg::coord_type           req_rect_bottom,
   input  wire logic [rrs_pkg::IDX_W-1:0]    req_entry_index,
   output logic                              rsp_valid,
   output logic [rrs_pkg::RCNT_W-1:0]        rsp_region_count,
   output logic                              rsp_error_out,
   output logic                              rsp_answer,
   output rrs_pkg::coord_type                rsp_out_left,
   output rrs_pkg::coord_type                rsp_out_top,
   output rrs_pkg::coord_type                rsp_out_right,
   output rrs_pkg::coord_type                rsp_out_bottom
);
   logic              push, q_full, q_not_empty, pop;
   rrs_pkg::cmd_type  f_cmd, q_cmd;
   rrs_pkg::rsp_type  rsp;

   rrs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_rect_left   (req_rect_left),
      .req_rect_top    (req_rect_top),
      .req_rect_right  (req_rect_right),
      .req_rect_bottom (req_rect_bottom),
      .req_entry_index (req_entry_index),
      .q_full          (q_full),
      .push            (push),
      .cmd             (f_cmd)
   );

   rrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_cmd    (f_cmd),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (pop),
      .rd_cmd    (q_cmd)
   );

   rrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (q_cmd),
      .cmd_pop   (pop),
      .rsp       (rsp)
   );

   assign rsp_valid        = rsp.valid;
   assign rsp_region_count = rsp.count;
   assign rsp_error_out    = rsp.err;
   assign rsp_answer       = rsp.ans;
   assign rsp_out_left     = rsp.o.l;
   assign rsp_out_top      = rsp.o.t;
   assign rsp_out_right    = rsp.o.r;
   assign rsp_out_bottom   = rsp.o.b;
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for rectangle_region_store: random and directed region commands.
// Predicts every response with a local region model held in a scoreboard class.
// Depends on rrs_pkg and the rectangle_region_store RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXN = rrs_pkg::CAPACITY;
   localparam int MAXP = rrs_pkg::SCRATCH_CAPACITY;

   typedef struct {
      logic [4:0]        count;
      logic              err;
      logic              ans;
      logic signed [15:0] l, t, r, b;
   } region_word_type;

   typedef struct {
      int l, t, r, b;
   } ibox_type;

   class scoreboard_type;
      ibox_type         rects[MAXN];
      int               nrect;
      bit               errf;
      ibox_type         pieces[MAXP];
      int               npiece;
      region_word_type  pending[$];
      int               fails;
      int               checked;
      int               hits;

      function new();
         nrect = 0; errf = 0; npiece = 0; fails = 0; checked = 0; hits = 0;
      endfunction

      function bit empty_box(ibox_type a);
         return a.r <= a.l || a.b <= a.t;
      endfunction

      function int wrap16(int v);
         logic signed [15:0] w;
         w = v[15:0];
         return int'(w);
      endfunction

      function ibox_type mkbox(int l, int t, int r, int b);
         ibox_type x;
         x.l = l; x.t = t; x.r = r; x.b = b;
         return x;
      endfunction

      function bit push_rect(bit to_pieces, ibox_type a);
         if (to_pieces) begin
            if (npiece >= MAXP) return 0;
            pieces[npiece] = a; npiece++;
         end else begin
            if (nrect >= MAXN) return 0;
            rects[nrect] = a; nrect++;
         end
         return 1;
      endfunction

      function void drop_at(bit to_pieces, int i);
         if (to_pieces) begin
            npiece--;
            for (int k = i; k < npiece; k++) pieces[k] = pieces[k + 1];
         end else begin
            nrect--;
            for (int k = i; k < nrect; k++) rects[k] = rects[k + 1];
         end
      endfunction

      function bit carve(bit to_pieces, ibox_type s);
         int       i;
         int       lim;
         ibox_type e;
         ibox_type c;
         bit       ok;
         i = 0;
         lim = to_pieces ? npiece : nrect;
         if (empty_box(s)) return 1;
         while (i < lim) begin
            e = to_pieces ? pieces[i] : rects[i];
            if (e.r > s.l && e.b > s.t && e.l < s.r && e.t < s.b) begin
               ok = 1;
               c.l = e.l > s.l ? e.l : s.l;
               c.t = e.t > s.t ? e.t : s.t;
               c.r = e.r < s.r ? e.r : s.r;
               c.b = e.b < s.b ? e.b : s.b;
               drop_at(to_pieces, i);
               if (ok && c.b != e.b) ok = push_rect(to_pieces, mkbox(e.l, c.b, e.r, e.b));
               if (ok && c.t != e.t) ok = push_rect(to_pieces, mkbox(e.l, e.t, e.r, c.t));
               if (ok && c.r != e.r) ok = push_rect(to_pieces, mkbox(c.r, c.t, e.r, c.b));
               if (ok && c.l != e.l) ok = push_rect(to_pieces, mkbox(e.l, c.t, c.l, c.b));
               if (!ok) return 0;
               lim--;
            end else begin
               i++;
            end
         end
         return 1;
      endfunction

      function void merge_rect(ibox_type a);
         bit covers;
         covers = 1;
         if (empty_box(a) || errf) return;
         for (int i = 0; i < nrect; i++)
            if (rects[i].l < a.l || rects[i].r > a.r || rects[i].t < a.t || rects[i].b > a.b)
               covers = 0;
         if (covers) begin
            rects[0] = a; nrect = 1;
            return;
         end
         pieces[0] = a; npiece = 1;
         for (int i = 0; i < nrect; i++)
            if (!carve(1, rects[i])) begin
               npiece = 0; nrect = 0; errf = 1;
               return;
            end
         for (int i = 0; i < npiece; i++)
            if (!push_rect(0, pieces[i])) begin
               nrect = 0; errf = 1;
               return;
            end
      endfunction

      function void note_command(logic [3:0] act, ibox_type a, logic [3:0] idx);
         region_word_type w;
         ibox_type        o;
         int              i;
         bit              ans;
         ans = 0;
         o = mkbox(0, 0, 0, 0);
         case (act)
            rrs_pkg::ACT_CLEAR: begin
               nrect = 0; errf = 0;
            end
            rrs_pkg::ACT_ADD: merge_rect(a);
            rrs_pkg::ACT_SUB: if (!carve(0, a)) begin
               nrect = 0; errf = 1;
            end
            rrs_pkg::ACT_CLIP: begin
               i = 0;
               while (i < nrect) begin
                  if (rects[i].l < a.l) rects[i].l = a.l;
                  if (rects[i].t < a.t) rects[i].t = a.t;
                  if (rects[i].r > a.r) rects[i].r = a.r;
                  if (rects[i].b > a.b) rects[i].b = a.b;
                  if (empty_box(rects[i])) drop_at(0, i);
                  else i++;
               end
            end
            rrs_pkg::ACT_HIT:
               for (i = 0; i < nrect; i++)
                  if (a.l >= rects[i].l && a.l < rects[i].r &&
                      a.t >= rects[i].t && a.t < rects[i].b) ans = 1;
            rrs_pkg::ACT_OVL:
               if (!empty_box(a))
                  for (i = 0; i < nrect; i++)
                     if (!empty_box(rects[i]) && rects[i].r > a.l && rects[i].l < a.r &&
                         rects[i].b > a.t && rects[i].t < a.b) ans = 1;
            rrs_pkg::ACT_BOUNDS:
               if (nrect > 0) begin
                  o = rects[0];
                  for (i = 1; i < nrect; i++) begin
                     if (rects[i].l < o.l) o.l = rects[i].l;
                     if (rects[i].t < o.t) o.t = rects[i].t;
                     if (rects[i].r > o.r) o.r = rects[i].r;
                     if (rects[i].b > o.b) o.b = rects[i].b;
                  end
               end
            rrs_pkg::ACT_OFFSET:
               for (i = 0; i < nrect; i++) begin
                  rects[i].l = wrap16(rects[i].l + a.l);
                  rects[i].r = wrap16(rects[i].r + a.l);
                  rects[i].t = wrap16(rects[i].t + a.t);
                  rects[i].b = wrap16(rects[i].b + a.t);
               end
            rrs_pkg::ACT_READ:
               if (idx < nrect) begin
                  ans = 1; o = rects[idx];
               end
            default: ;
         endcase
         if (ans) hits++;
         w.count = nrect[4:0];
         w.err = errf;
         w.ans = ans;
         w.l = o.l[15:0]; w.t = o.t[15:0]; w.r = o.r[15:0]; w.b = o.b[15:0];
         pending.push_back(w);
      endfunction

      function void check_word(region_word_type got);
         region_word_type w;
         if (pending.size() == 0) begin
            $display("%0t: response with none expected: count %0d", $realtime, got.count);
            fails++;
            return;
         end
         w = pending.pop_front();
         checked++;
         if (got.count !== w.count || got.err !== w.err || got.ans !== w.ans ||
             got.l !== w.l || got.t !== w.t || got.r !== w.r || got.b !== w.b) begin
            $display("%0t: mismatch expected cnt=%0d err=%0b ans=%0b box=(%0d,%0d,%0d,%0d)",
                     $realtime, w.count, w.err, w.ans, w.l, w.t, w.r, w.b);
            $display("%0t:          actual   cnt=%0d err=%0b ans=%0b box=(%0d,%0d,%0d,%0d)",
                     $realtime, got.count, got.err, got.ans, got.l, got.t, got.r, got.b);
            fails++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic [3:0]                 req_action;
   rrs_pkg::coord_type         req_rect_left, req_rect_top, req_rect_right, req_rect_bottom;
   logic [3:0]                 req_entry_index;
   logic                       rsp_valid;
   logic [rrs_pkg::RCNT_W-1:0] rsp_region_count;
   logic                       rsp_error_out;
   logic                       rsp_answer;
   rrs_pkg::coord_type         rsp_out_left, rsp_out_top, rsp_out_right, rsp_out_bottom;

   scoreboard_type sb;

   rectangle_region_store dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_rect_left(req_rect_left),
      .req_rect_top(req_rect_top), .req_rect_right(req_rect_right),
      .req_rect_bottom(req_rect_bottom), .req_entry_index(req_entry_index),
      .rsp_valid(rsp_valid), .rsp_region_count(rsp_region_count),
      .rsp_error_out(rsp_error_out), .rsp_answer(rsp_answer),
      .rsp_out_left(rsp_out_left), .rsp_out_top(rsp_out_top),
      .rsp_out_right(rsp_out_right), .rsp_out_bottom(rsp_out_bottom)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      region_word_type got;
      if (!reset && rsp_valid) begin
         got.count = rsp_region_count;
         got.err = rsp_error_out;
         got.ans = rsp_answer;
         got.l = rsp_out_left; got.t = rsp_out_top;
         got.r = rsp_out_right; got.b = rsp_out_bottom;
         sb.check_word(got);
      end
   end

   task automatic send_command(logic [3:0] act, int l, int t, int r, int b, logic [3:0] idx);
      ibox_type a;
      a.l = int'($signed(l[15:0])); a.t = int'($signed(t[15:0]));
      a.r = int'($signed(r[15:0])); a.b = int'($signed(b[15:0]));
      start <= 1;
      req_action <= act;
      req_rect_left <= l[15:0]; req_rect_top <= t[15:0];
      req_rect_right <= r[15:0]; req_rect_bottom <= b[15:0];
      req_entry_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_command(act, a, idx);
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 99) < 70 ? 0 :
          ($urandom_range(0, 9) < 8 ? $urandom_range(1, 4) : $urandom_range(10, 80));
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic int pick_coord(bit wide);
      if (wide && $urandom_range(0, 3) == 0) return int'($signed(16'($urandom)));
      return $urandom_range(0, 40) - 20;
   endfunction

   task automatic send_random();
      int  l, t, r, b;
      int  k;
      logic [3:0] act;
      bit  wide;
      wide = $urandom_range(0, 9) == 0;
      l = pick_coord(wide); t = pick_coord(wide);
      r = $urandom_range(0, 4) == 0 ? pick_coord(wide) : l + $urandom_range(1, 16);
      b = $urandom_range(0, 4) == 0 ? pick_coord(wide) : t + $urandom_range(1, 16);
      k = $urandom_range(0, 99);
      if (k < 30) act = rrs_pkg::ACT_ADD;
      else if (k < 45) act = rrs_pkg::ACT_SUB;
      else if (k < 50) act = rrs_pkg::ACT_CLIP;
      else if (k < 60) act = rrs_pkg::ACT_HIT;
      else if (k < 68) act = rrs_pkg::ACT_OVL;
      else if (k < 74) act = rrs_pkg::ACT_BOUNDS;
      else if (k < 78) act = rrs_pkg::ACT_OFFSET;
      else if (k < 92) act = rrs_pkg::ACT_READ;
      else if (k < 95) act = rrs_pkg::ACT_CLEAR;
      else act = 4'($urandom_range(9, 15));
      if (act == rrs_pkg::ACT_OFFSET) begin
         l = $urandom_range(0, 7) == 0 ? int'($urandom) : $urandom_range(0, 8) - 4;
         t = $urandom_range(0, 7) == 0 ? int'($urandom) : $urandom_range(0, 8) - 4;
      end
      send_command(act, l, t, r, b, 4'($urandom));
   endtask

   initial begin
      int nrand;
      sb = new();
      reset = 1;
      start = 0;
      req_action = rrs_pkg::ACT_CLEAR;
      req_rect_left = 0; req_rect_top = 0; req_rect_right = 0; req_rect_bottom = 0;
      req_entry_index = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_command(rrs_pkg::ACT_BOUNDS, 0, 0, 0, 0, 0);
      send_command(rrs_pkg::ACT_READ, 0, 0, 0, 0, 15);
      send_command(rrs_pkg::ACT_ADD, -32768, -32768, 32767, 32767, 0);
      send_command(rrs_pkg::ACT_ADD, 5, 5, 5, 9, 0);
      send_command(rrs_pkg::ACT_ADD, 0, 0, 10, 10, 0);
      send_command(rrs_pkg::ACT_ADD, 5, 5, 20, 20, 0);
      send_command(rrs_pkg::ACT_HIT, 0, 0, 0, 0, 0);
      send_command(rrs_pkg::ACT_HIT, 10, 10, 0, 0, 0);
      send_command(rrs_pkg::ACT_OVL, 19, 19, 30, 30, 0);
      send_command(rrs_pkg::ACT_OVL, 3, 3, 3, 30, 0);
      send_command(rrs_pkg::ACT_SUB, 2, 2, 4, 4, 0);
      send_command(rrs_pkg::ACT_SUB, 1, 1, 0, 0, 0);
      send_command(rrs_pkg::ACT_READ, 0, 0, 0, 0, 0);
      send_command(rrs_pkg::ACT_READ, 0, 0, 0, 0, 15);
      send_command(rrs_pkg::ACT_BOUNDS, 0, 0, 0, 0, 0);
      send_command(rrs_pkg::ACT_OFFSET, 32767, -32768, 0, 0, 0);
      send_command(rrs_pkg::ACT_CLIP, -32768, -32768, 32767, 0, 0);
      send_command(rrs_pkg::ACT_READ, 0, 0, 0, 0, 1);
      send_command(4'd15, -1, -1, -1, -1, 15);
      for (int i = 0; i < 6; i++)
         send_command(rrs_pkg::ACT_ADD, i * 2, 0, i * 2 + 1, 30, 0);
      send_command(rrs_pkg::ACT_ADD, -5, 3, 40, 5, 0);
      send_command(rrs_pkg::ACT_ADD, 0, 0, 1, 1, 0);
      send_command(rrs_pkg::ACT_CLEAR, 0, 0, 0, 0, 0);
      nrand = 0;
      while (nrand < 750) begin
         idle_gap();
         send_random();
         nrand++;
      end
      start <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Checked %0d responses (%0d with answer set) over %0d random commands.",
               sb.checked, sb.hits, nrand);
      if (sb.fails == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

   initial begin
      #100ms;
      $display("tb_top failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/rrs_pkg.sv
design/rrs_front.sv
design/rrs_queue.sv
design/rrs_back.sv
design/rectangle_region_store.sv
tb/tb_top.sv
